[design/mmsl_pkg.sv]
package mmsl_pkg;

  // Default channel count; the top level can be built for fewer.
  localparam int NUM_CHANNELS_DEF = 8;

  // Field widths.
  localparam int CH_W      = 3;
  localparam int CMD_W     = 9;
  localparam int DRV_W     = 8;
  localparam int ELAPSED_W = 10;
  localparam int RATE_W    = 8;
  localparam int RATE_FRAC = 4;
  localparam int PROD_W    = RATE_W + ELAPSED_W;
  localparam int STEP_W    = PROD_W - RATE_FRAC;
  localparam int MASK_W    = 8;
  localparam int RATES_W   = 64;

  // Stream widths.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERTED_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATES    = 1'b1;

  // Input actions carried on s_tuser.
  localparam logic [S_TUSER_W-1:0] ACT_SET  = 2'd0;
  localparam logic [S_TUSER_W-1:0] ACT_TICK = 2'd1;
  localparam logic [S_TUSER_W-1:0] ACT_READ = 2'd2;

  // Result kinds carried on m_tuser.
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Drive limits.
  localparam logic signed [CMD_W-1:0] CMD_POS_LIM = 9'sd127;
  localparam logic signed [CMD_W-1:0] CMD_NEG_LIM = -9'sd127;
  localparam logic signed [DRV_W-1:0] DRV_POS_LIM = 8'sd127;
  localparam logic signed [DRV_W-1:0] DRV_NEG_LIM = -8'sd127;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_EMIT
  } state_t;

  // Operand load for the shared ramp unit.
  typedef struct packed {
    logic                        load;
    logic [RATE_W-1:0]           rate;
    logic [ELAPSED_W-1:0]        elapsed;
    logic signed [DRV_W-1:0]     tgt;
    logic signed [DRV_W-1:0]     cur;
  } ramp_req_t;

endpackage

[design/mmsl_ramp_unit.sv]
module mmsl_ramp_unit (
  input  logic                                clk,
  input  mmsl_pkg::ramp_req_t                 req,
  output logic signed [mmsl_pkg::DRV_W-1:0]   nxt
);

  logic [mmsl_pkg::PROD_W-1:0]        prod;
  logic signed [mmsl_pkg::DRV_W-1:0]  tgt;
  logic signed [mmsl_pkg::DRV_W-1:0]  cur;
  logic [mmsl_pkg::STEP_W-1:0]        step;
  logic                               up;
  logic signed [mmsl_pkg::DRV_W:0]    diff;
  logic [mmsl_pkg::DRV_W-1:0]         absdiff;
  logic                               reach;
  logic [mmsl_pkg::DRV_W-1:0]         moved;

  // Operand registers; the rate times elapsed product is taken here.
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= mmsl_pkg::PROD_W'(req.rate) * mmsl_pkg::PROD_W'(req.elapsed);
      tgt  <= req.tgt;
      cur  <= req.cur;
    end
  end

  // Step toward the target, stopping at it.
  always_comb begin
    step    = mmsl_pkg::STEP_W'(prod >> mmsl_pkg::RATE_FRAC);
    up      = tgt > cur;
    diff    = up ? ((mmsl_pkg::DRV_W+1)'(tgt) - (mmsl_pkg::DRV_W+1)'(cur))
                 : ((mmsl_pkg::DRV_W+1)'(cur) - (mmsl_pkg::DRV_W+1)'(tgt));
    absdiff = diff[mmsl_pkg::DRV_W-1:0];
    reach   = step >= mmsl_pkg::STEP_W'(absdiff);
    // When the target is not reached the step is below the distance,
    // so its low byte is the whole step and the sum stays in range.
    moved   = up ? (cur + step[mmsl_pkg::DRV_W-1:0])
                 : (cur - step[mmsl_pkg::DRV_W-1:0]);
    nxt     = reach ? tgt : signed'(moved);
  end

endmodule

[design/multichannel_motor_slew_limiter.sv]
// Per-channel motor slew limiter. A set beat (tuser 0) clamps its command to
// +/-127, applies the channel inversion and stores it as the target; with the
// immediate bit it also returns one drive result. A read beat (tuser 2)
// returns the uninverted target. A tick beat (tuser 1) walks the channels in
// ascending order and, for each channel whose drive differs from its target
// and whose rate is nonzero, moves the ramp toward the target by
// floor(rate * elapsed_ms / 16) and returns the new drive; tlast marks the
// final result of a beat. A set or read is taken while idle; its result is
// registered as the pending result and then loaded into the output register
// in the emit state. A tick skips each channel it does not update in the scan
// state and takes each channel it updates through the scan, step and emit states,
// because every update goes through the one multiply and clamp unit. s_tready
// is low until the current beat has finished; configuration writes are always
// taken.
module multichannel_motor_slew_limiter #(
  parameter int NUM_CHANNELS = mmsl_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmsl_pkg::RATES_W-1:0]        cfg_data,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // channel[2:0], command_in[11:3], immediate[12], elapsed_ms[22:13], zero[23]
  input  logic [mmsl_pkg::S_TDATA_W-1:0]      s_tdata,
  // action[1:0]
  input  logic [mmsl_pkg::S_TUSER_W-1:0]      s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // out_channel[2:0], value[10:3], zero[15:11]
  output logic [mmsl_pkg::M_TDATA_W-1:0]      m_tdata,
  // kind[0]
  output logic                                m_tuser,
  output logic                                m_tlast
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  // Configuration and channel state.
  logic [mmsl_pkg::MASK_W-1:0]         inv_mask;
  logic [mmsl_pkg::RATES_W-1:0]        rates;
  logic signed [mmsl_pkg::DRV_W-1:0]   target [NUM_CHANNELS];
  logic signed [mmsl_pkg::DRV_W-1:0]   ramp [NUM_CHANNELS];
  logic signed [mmsl_pkg::DRV_W-1:0]   applied [NUM_CHANNELS];

  // Sequencer.
  mmsl_pkg::state_t                    st, st_next;
  logic [IDX_W-1:0]                    cnt;
  logic                                tick_mode;
  logic [NUM_CHANNELS-1:0]             mask;
  logic [mmsl_pkg::ELAPSED_W-1:0]      elapsed;

  // Pending result.
  logic                                res_kind;
  logic [mmsl_pkg::CH_W-1:0]           res_ch;
  logic signed [mmsl_pkg::DRV_W-1:0]   res_val;
  logic                                res_last;

  // Output register.
  logic [mmsl_pkg::CH_W-1:0]           out_ch;
  logic signed [mmsl_pkg::DRV_W-1:0]   out_val;

  // Input fields.
  logic [mmsl_pkg::S_TUSER_W-1:0]      in_action;
  logic [mmsl_pkg::CH_W-1:0]           in_ch;
  logic signed [mmsl_pkg::CMD_W-1:0]   in_cmd;
  logic                                in_imm;
  logic [mmsl_pkg::ELAPSED_W-1:0]      in_elapsed;
  logic [IDX_W-1:0]                    in_idx;
  logic                                ch_ok;
  logic signed [mmsl_pkg::DRV_W-1:0]   clamped;
  logic signed [mmsl_pkg::DRV_W-1:0]   set_cmd;
  logic signed [mmsl_pkg::DRV_W-1:0]   read_val;
  logic [NUM_CHANNELS-1:0]             active;

  // Control.
  logic                                accept;
  logic                                set_write;
  logic                                imm_drive;
  logic                                tick_start;
  logic                                read_start;
  logic                                scan_hit;
  logic                                at_last;
  logic                                step_write;
  logic                                out_free;
  logic                                emit_load;
  logic                                cnt_inc;
  mmsl_pkg::ramp_req_t                 ramp_req;
  logic signed [mmsl_pkg::DRV_W-1:0]   ramp_nxt;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mask <= '0;
      rates    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmsl_pkg::CFG_INVERTED_MASK: inv_mask <= cfg_data[mmsl_pkg::MASK_W-1:0];
        mmsl_pkg::CFG_SLEW_RATES:    rates    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the input beat.
  assign in_action  = s_tuser;
  assign in_ch      = s_tdata[2:0];
  assign in_cmd     = signed'(s_tdata[11:3]);
  assign in_imm     = s_tdata[12];
  assign in_elapsed = s_tdata[22:13];
  assign in_idx     = in_ch[IDX_W-1:0];
  assign ch_ok      = (mmsl_pkg::CH_W+1)'(in_ch) < (mmsl_pkg::CH_W+1)'(NUM_CHANNELS);

  // Clamp and invert a new command; undo the inversion on readback.
  always_comb begin
    if (in_cmd > mmsl_pkg::CMD_POS_LIM) begin
      clamped = mmsl_pkg::DRV_POS_LIM;
    end else if (in_cmd < mmsl_pkg::CMD_NEG_LIM) begin
      clamped = mmsl_pkg::DRV_NEG_LIM;
    end else begin
      clamped = in_cmd[mmsl_pkg::DRV_W-1:0];
    end
    set_cmd = inv_mask[in_ch] ? -clamped : clamped;
    if (!ch_ok) begin
      read_val = '0;
    end else if (inv_mask[in_ch]) begin
      read_val = -target[in_idx];
    end else begin
      read_val = target[in_idx];
    end
  end

  // Channels that a tick would update, taken once at the start of the tick.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_active
    assign active[i] = (applied[i] != target[i])
                     && (rates[mmsl_pkg::RATE_W*i +: mmsl_pkg::RATE_W] != '0);
  end

  assign accept   = s_tvalid && s_tready;
  assign scan_hit = mask[cnt];
  assign at_last  = cnt == LAST_IDX;
  assign out_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    st_next = st;
    unique case (st)
      mmsl_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (in_action)
            mmsl_pkg::ACT_SET:  if (ch_ok && in_imm) st_next = mmsl_pkg::ST_EMIT;
            mmsl_pkg::ACT_TICK: st_next = mmsl_pkg::ST_SCAN;
            mmsl_pkg::ACT_READ: st_next = mmsl_pkg::ST_EMIT;
            default: ;
          endcase
        end
      end
      mmsl_pkg::ST_SCAN: begin
        if (scan_hit) begin
          st_next = mmsl_pkg::ST_STEP;
        end else if (at_last) begin
          st_next = mmsl_pkg::ST_IDLE;
        end
      end
      mmsl_pkg::ST_STEP: st_next = mmsl_pkg::ST_EMIT;
      mmsl_pkg::ST_EMIT: begin
        if (out_free) begin
          st_next = (tick_mode && !at_last) ? mmsl_pkg::ST_SCAN : mmsl_pkg::ST_IDLE;
        end
      end
      default: st_next = mmsl_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready   = 1'b0;
    set_write  = 1'b0;
    imm_drive  = 1'b0;
    tick_start = 1'b0;
    read_start = 1'b0;
    step_write = 1'b0;
    emit_load  = 1'b0;
    cnt_inc    = 1'b0;
    unique case (st)
      mmsl_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        set_write  = s_tvalid && (in_action == mmsl_pkg::ACT_SET) && ch_ok;
        imm_drive  = set_write && in_imm;
        tick_start = s_tvalid && (in_action == mmsl_pkg::ACT_TICK);
        read_start = s_tvalid && (in_action == mmsl_pkg::ACT_READ);
      end
      mmsl_pkg::ST_SCAN: cnt_inc = !scan_hit && !at_last;
      mmsl_pkg::ST_STEP: step_write = 1'b1;
      mmsl_pkg::ST_EMIT: begin
        emit_load = out_free;
        cnt_inc   = out_free && tick_mode && !at_last;
      end
      default: ;
    endcase
  end

  // Operands for the shared ramp unit.
  always_comb begin
    ramp_req.load    = (st == mmsl_pkg::ST_SCAN) && scan_hit;
    ramp_req.rate    = mmsl_pkg::RATE_W'(rates >> {cnt, 3'b000});
    ramp_req.elapsed = elapsed;
    ramp_req.tgt     = target[cnt];
    ramp_req.cur     = ramp[cnt];
  end

  mmsl_ramp_unit u_ramp (
    .clk (clk),
    .req (ramp_req),
    .nxt (ramp_nxt)
  );

  // State register and channel counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= mmsl_pkg::ST_IDLE;
      cnt       <= '0;
      tick_mode <= 1'b0;
    end else begin
      st <= st_next;
      if (accept) begin
        cnt       <= '0;
        tick_mode <= tick_start;
      end else if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Channel state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        target[i]  <= '0;
        ramp[i]    <= '0;
        applied[i] <= '0;
      end
    end else begin
      if (set_write) begin
        target[in_idx] <= set_cmd;
      end
      if (imm_drive) begin
        applied[in_idx] <= set_cmd;
      end
      if (step_write) begin
        ramp[cnt]    <= ramp_nxt;
        applied[cnt] <= ramp_nxt;
      end
    end
  end

  // Tick operands and the pending result.
  always_ff @(posedge clk) begin
    if (tick_start) begin
      mask    <= active;
      elapsed <= in_elapsed;
    end
    if (imm_drive) begin
      res_kind <= mmsl_pkg::KIND_DRIVE;
      res_ch   <= in_ch;
      res_val  <= set_cmd;
      res_last <= 1'b1;
    end else if (read_start) begin
      res_kind <= mmsl_pkg::KIND_READ;
      res_ch   <= in_ch;
      res_val  <= read_val;
      res_last <= 1'b1;
    end else if (step_write) begin
      res_kind <= mmsl_pkg::KIND_DRIVE;
      res_ch   <= mmsl_pkg::CH_W'(cnt);
      res_val  <= ramp_nxt;
      // Last when no channel above this one is due for an update.
      res_last <= (mask >> cnt) == NUM_CHANNELS'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tuser <= res_kind;
      out_ch  <= res_ch;
      out_val <= res_val;
      m_tlast <= res_last;
    end
  end

  assign m_tdata = {5'b0, out_val, out_ch};

endmodule

[bench/mmsl_drive_checker.sv]
`timescale 1ns / 100ps

// Watches the configuration, input and result channels of the slew limiter,
// predicts every drive update and readback, and compares the results in order.
module mmsl_drive_checker
  import mmsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATES_W-1:0]   cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tuser,
  input  logic                 m_tlast,
  output int                   fail_count,
  output int                   awaited_count
);

  typedef struct packed {
    logic                    kind;
    logic [CH_W-1:0]         ch;
    logic signed [DRV_W-1:0] value;
    logic                    last;
  } motor_result_t;

  // Results still owed by the block, oldest first.
  motor_result_t awaited_results[$];

  // Private copy of the per-channel state and the registers.
  logic signed [DRV_W-1:0] target_cmd [NUM_CHANNELS_DEF];
  logic signed [DRV_W-1:0] ramp_level [NUM_CHANNELS_DEF];
  logic signed [DRV_W-1:0] drive_level[NUM_CHANNELS_DEF];
  logic [MASK_W-1:0]       inv_mask;
  logic [RATES_W-1:0]      slew_rates;

  // One result is held back so that the final one of a beat can carry last.
  motor_result_t staged;
  bit            staged_valid = 1'b0;

  int mismatches = 0;
  int owed       = 0;

  assign fail_count    = mismatches;
  assign awaited_count = owed;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic stage_result(input logic kind, input logic [CH_W-1:0] ch,
                              input logic signed [DRV_W-1:0] value);
    if (staged_valid) begin
      awaited_results.push_back(staged);
    end
    staged.kind  = kind;
    staged.ch    = ch;
    staged.value = value;
    staged.last  = 1'b0;
    staged_valid = 1'b1;
  endtask

  // Applies one accepted input beat to the channel state and queues its results.
  task automatic predict_beat(input logic [S_TUSER_W-1:0] act, input logic [CH_W-1:0] ch,
                              input logic signed [CMD_W-1:0] cmd_raw, input logic imm,
                              input logic [ELAPSED_W-1:0] elapsed);
    int cmd;
    int rate;
    int step;
    int tgt;
    int cur;
    int nxt;
    case (act)
      ACT_SET: begin
        cmd = int'(cmd_raw);
        if (cmd > 127) begin
          cmd = 127;
        end else if (cmd < -127) begin
          cmd = -127;
        end
        if (inv_mask[ch]) begin
          cmd = -cmd;
        end
        target_cmd[ch] = cmd[DRV_W-1:0];
        if (imm) begin
          drive_level[ch] = cmd[DRV_W-1:0];
          stage_result(KIND_DRIVE, ch, cmd[DRV_W-1:0]);
        end
      end
      ACT_TICK: begin
        // Channels are visited in ascending order; settled or disabled ones are skipped.
        for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
          rate = int'(slew_rates[8*i +: 8]);
          if (drive_level[i] != target_cmd[i] && rate != 0) begin
            step = (rate * int'(elapsed)) >> RATE_FRAC;
            tgt  = int'(target_cmd[i]);
            cur  = int'(ramp_level[i]);
            nxt  = cur;
            if (tgt > cur) begin
              nxt = (cur + step > tgt) ? tgt : cur + step;
            end else if (tgt < cur) begin
              nxt = (cur - step < tgt) ? tgt : cur - step;
            end
            ramp_level[i]  = nxt[DRV_W-1:0];
            drive_level[i] = nxt[DRV_W-1:0];
            stage_result(KIND_DRIVE, i[CH_W-1:0], nxt[DRV_W-1:0]);
          end
        end
      end
      ACT_READ: begin
        cmd = int'(target_cmd[ch]);
        if (inv_mask[ch]) begin
          cmd = -cmd;
        end
        stage_result(KIND_READ, ch, cmd[DRV_W-1:0]);
      end
      default: begin
      end
    endcase
    if (staged_valid) begin
      staged.last = 1'b1;
      awaited_results.push_back(staged);
      staged_valid = 1'b0;
    end
  endtask

  // Prediction on input beats, comparison on result beats.
  always @(posedge clk) begin
    motor_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
        target_cmd[i]  = '0;
        ramp_level[i]  = '0;
        drive_level[i] = '0;
      end
      inv_mask   = '0;
      slew_rates = '0;
      awaited_results.delete();
      staged_valid = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INVERTED_MASK: inv_mask = cfg_data[MASK_W-1:0];
          CFG_SLEW_RATES: slew_rates = cfg_data;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_beat(s_tuser, s_tdata[2:0], s_tdata[11:3], s_tdata[12], s_tdata[22:13]);
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited", -1,
                          int'($signed(m_tdata[10:3])));
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser != want.kind) begin
            report_mismatch("kind", int'(want.kind), int'(m_tuser));
          end
          if (m_tdata[2:0] != want.ch) begin
            report_mismatch("channel", int'(want.ch), int'(m_tdata[2:0]));
          end
          if ($signed(m_tdata[10:3]) != want.value) begin
            report_mismatch($sformatf("value on channel %0d", want.ch), int'(want.value),
                            int'($signed(m_tdata[10:3])));
          end
          if (m_tlast != want.last) begin
            report_mismatch($sformatf("tlast on channel %0d", want.ch), int'(want.last),
                            int'(m_tlast));
          end
        end
      end
    end
    owed <= awaited_results.size();
  end

endmodule

[bench/tb_multichannel_motor_slew_limiter.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the slew limiter; checking lives in mmsl_drive_checker.
module tb_multichannel_motor_slew_limiter;
  import mmsl_pkg::*;

  localparam logic [S_TUSER_W-1:0] ACT_UNUSED = 2'd3;
  // Settling margin, sized for a tick that updates every channel.
  localparam int SETTLE_CYCLES     = 3 * NUM_CHANNELS_DEF + 6;
  localparam int QUIET_LIMIT       = 2000;
  localparam int SEGMENTS          = 8;
  localparam int ITEMS_PER_SEGMENT = 52;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATES_W-1:0]   cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_ready;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  int fail_count;
  int awaited;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  int idle_of_mode[4]  = '{0, 47, 0, 27};
  int stall_of_mode[4] = '{0, 0, 47, 27};

  always #6 clk = ~clk;

  multichannel_motor_slew_limiter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  mmsl_drive_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .fail_count   (fail_count),
    .awaited_count(awaited)
  );

  // Result side back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: ends the run after too many cycles without any beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Presents one input beat after a random gap and returns once it is taken.
  task automatic send_item(input logic [S_TUSER_W-1:0] act, input logic [CH_W-1:0] ch,
                           input logic [CMD_W-1:0] cmd, input logic imm,
                           input logic [ELAPSED_W-1:0] elapsed);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, elapsed, imm, cmd, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Waits until every awaited result has arrived and the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers, inversion mask first.
  task automatic set_regs(input logic [MASK_W-1:0] mask, input logic [RATES_W-1:0] rates);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INVERTED_MASK;
    cfg_data  <= {{(RATES_W-MASK_W){1'b0}}, mask};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_SLEW_RATES;
    cfg_data  <= rates;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [S_TUSER_W-1:0] act;
    logic [CH_W-1:0]      ch;
    logic [CMD_W-1:0]     cmd;
    logic                 imm;
    logic [ELAPSED_W-1:0] elapsed;
    logic [MASK_W-1:0]    mask;
    logic [RATES_W-1:0]   rates;
    int                   pick;
    int                   done_items;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, clamping at both extremes, no ramping yet.
    send_item(ACT_READ, 3'd0, 9'h000, 1'b0, 10'd0);
    send_item(ACT_SET, 3'd0, 9'h0FF, 1'b1, 10'd0);
    send_item(ACT_SET, 3'd7, 9'h100, 1'b1, 10'h3FF);
    send_item(ACT_SET, 3'd2, -9'sd5, 1'b0, 10'd0);
    send_item(ACT_TICK, 3'd7, 9'h1FF, 1'b1, 10'h3FF);
    send_item(ACT_UNUSED, 3'd5, 9'h055, 1'b1, 10'd7);
    send_item(ACT_READ, 3'd7, 9'h1FF, 1'b1, 10'h3FF);

    // Mixed rates and inversion: partial steps, zero elapsed time, ramp already at target.
    settle();
    set_regs(8'hA5, 64'hFF00_1001_FF08_0010);
    send_item(ACT_TICK, 3'd0, 9'h000, 1'b0, 10'd3);
    send_item(ACT_SET, 3'd5, 9'd60, 1'b0, 10'd0);
    send_item(ACT_TICK, 3'd0, 9'h000, 1'b0, 10'd0);
    send_item(ACT_SET, 3'd4, 9'd50, 1'b1, 10'd0);
    send_item(ACT_SET, 3'd4, 9'd0, 1'b0, 10'd0);
    send_item(ACT_TICK, 3'd0, 9'h000, 1'b0, 10'h3FF);
    send_item(ACT_READ, 3'd5, 9'h000, 1'b0, 10'd0);
    send_item(ACT_READ, 3'd2, 9'h000, 1'b0, 10'd0);
    send_item(ACT_SET, 3'd3, -9'sd127, 1'b1, 10'h3FF);

    // All channels inverted at the fastest rate.
    settle();
    set_regs(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_SET, 3'd1, 9'h080, 1'b0, 10'd0);
    send_item(ACT_SET, 3'd6, 9'h180, 1'b0, 10'd0);
    send_item(ACT_TICK, 3'd0, 9'h000, 1'b0, 10'd1);
    send_item(ACT_TICK, 3'd0, 9'h000, 1'b0, 10'h3FF);
    send_item(ACT_READ, 3'd1, 9'h000, 1'b0, 10'd0);
    send_item(ACT_READ, 3'd6, 9'h000, 1'b0, 10'd0);

    // Random segments, each with its own settings and idling pattern.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      mask = MASK_W'($urandom);
      for (int b = 0; b < 8; b++) begin
        pick = $urandom_range(3);
        case (pick)
          0: rates[8*b +: 8] = 8'h00;
          1: rates[8*b +: 8] = 8'hFF;
          2: rates[8*b +: 8] = 8'($urandom_range(32, 1));
          default: rates[8*b +: 8] = 8'($urandom);
        endcase
      end
      if (seg == 0) begin
        mask  = 8'h00;
        rates = {8{8'hFF}};
      end else if (seg == 1) begin
        mask  = 8'hFF;
        rates = {8{8'h01}};
      end else if (seg == 2) begin
        rates = '0;
      end
      set_regs(mask, rates);
      send_idle_pct  = idle_of_mode[seg % 4];
      recv_stall_pct = stall_of_mode[seg % 4];

      done_items = 0;
      while (done_items < ITEMS_PER_SEGMENT) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          act = ACT_SET;
        end else if (pick < 75) begin
          act = ACT_TICK;
        end else if (pick < 95) begin
          act = ACT_READ;
        end else begin
          act = ACT_UNUSED;
        end
        ch  = CH_W'($urandom);
        imm = 1'($urandom);
        if ($urandom_range(9) < 6) begin
          cmd = CMD_W'($urandom_range(260) - 130);
        end else begin
          cmd = CMD_W'($urandom);
        end
        pick = $urandom_range(9);
        if (pick < 7) begin
          elapsed = ELAPSED_W'($urandom_range(12));
        end else if (pick < 9) begin
          elapsed = ELAPSED_W'($urandom_range(100));
        end else begin
          elapsed = ELAPSED_W'($urandom);
        end
        send_item(act, ch, cmd, imm, elapsed);
        if (act != ACT_UNUSED) begin
          done_items++;
        end
      end
    end

    settle();
    if (fail_count == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
